>>> hdl/device_registry_with_classify_unit_assert.svh
// Assertion macros for the device registry checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DEVICE_REGISTRY_WITH_CLASSIFY_UNIT_ASSERT_SVH
`define DEVICE_REGISTRY_WITH_CLASSIFY_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define DRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("device registry check failed");

// next-cycle implication, held off during reset
`define DRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("device registry check failed");

`endif

>>> hdl/devreg_pkg.sv
// Shared types, codes and constants of the device registry.
// No dependencies; imported by every registry module.
package devreg_pkg;

  typedef enum logic [1:0] {
    REQ_ATTACH = 2'd0,
    REQ_DETACH = 2'd1,
    REQ_SWEEP  = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_SWEPT    = 3'd4,
    ST_IGNORED  = 3'd5,
    ST_READ     = 3'd6
  } status_t;

  localparam logic [1:0] TR_KNOWN         = 2'd0;
  localparam logic [1:0] TR_UNKNOWN       = 2'd1;
  localparam logic [1:0] TR_SUSPICIOUS    = 2'd2;
  localparam logic [1:0] TRUST_CODE_UNDEF = 2'd3;

  localparam logic [2:0] CFG_KEY0    = 3'd0;
  localparam logic [2:0] CFG_KEY1    = 3'd1;
  localparam logic [2:0] CFG_KEY2    = 3'd2;
  localparam logic [2:0] CFG_TRUST   = 3'd3;
  localparam logic [2:0] CFG_HOST    = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT = 3'd5;

  localparam logic [31:0] KEY0_RST    = 32'd74301579;
  localparam logic [31:0] KEY1_RST    = 32'd125916561;
  localparam logic [31:0] KEY2_RST    = 32'd416370401;
  localparam logic [5:0]  TRUST_RST   = 6'd36;
  localparam logic [31:0] HOST_RST    = 32'd381682140;
  localparam logic [30:0] TIMEOUT_RST = 31'd30;

  localparam logic [3:0] BLINK_CNT_KNOWN      = 4'd3;
  localparam logic [3:0] BLINK_CNT_UNKNOWN    = 4'd5;
  localparam logic [3:0] BLINK_CNT_SUSPICIOUS = 4'd10;
  localparam logic [8:0] BLINK_HALF_KNOWN      = 9'd300;
  localparam logic [8:0] BLINK_HALF_UNKNOWN    = 9'd150;
  localparam logic [8:0] BLINK_HALF_SUSPICIOUS = 9'd80;

  localparam int CQ_DEPTH = 2;

  typedef struct packed {
    req_t        req_type;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [7:0]  device_class;
    logic [2:0]  link_speed;
    logic [31:0] now_time;
    logic [3:0]  read_slot;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  trust_level;
    logic [3:0]  slot_used;
    logic        slot_active;
    logic [15:0] out_vendor_id;
    logic [15:0] out_product_id;
    logic [7:0]  out_device_class;
    logic [2:0]  out_link_speed;
    logic [3:0]  blink_count;
    logic [8:0]  blink_half_period;
    logic [4:0]  swept_count;
  } out_word_t;

  typedef struct packed {
    logic [31:0] key0;
    logic [31:0] key1;
    logic [31:0] key2;
    logic [5:0]  trust_codes;
    logic [31:0] host_key;
    logic [30:0] timeout;
  } cls_cfg_t;

  typedef struct packed {
    req_t        req;
    logic        ignored;
    logic [1:0]  trust;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [7:0]  cls_code;
    logic [2:0]  speed;
    logic [31:0] now;
    logic [31:0] cutoff;
    logic [3:0]  read_slot;
  } cmd_t;

  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] product;
    logic [7:0]  cls_code;
    logic [2:0]  speed;
    logic [1:0]  trust;
    logic [31:0] stamp;
  } entry_t;

  function automatic logic [1:0] trust_of_code(input logic [1:0] code);
    return (code == TRUST_CODE_UNDEF) ? TR_UNKNOWN : code;
  endfunction

  function automatic logic [3:0] blink_count_of(input logic [1:0] trust);
    case (trust)
      TR_KNOWN:      return BLINK_CNT_KNOWN;
      TR_SUSPICIOUS: return BLINK_CNT_SUSPICIOUS;
      default:       return BLINK_CNT_UNKNOWN;
    endcase
  endfunction

  function automatic logic [8:0] blink_half_of(input logic [1:0] trust);
    case (trust)
      TR_KNOWN:      return BLINK_HALF_KNOWN;
      TR_SUSPICIOUS: return BLINK_HALF_SUSPICIOUS;
      default:       return BLINK_HALF_UNKNOWN;
    endcase
  endfunction

endpackage

>>> hdl/devreg_front.sv
// Front end: takes input words, classifies vendor:product and forms commands.
// Depends on devreg_pkg.
module devreg_front import devreg_pkg::*; (
  input  logic     in_push,
  output logic     in_full,
  input  in_word_t in_word,
  input  cls_cfg_t cfg,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_data
);

  logic [31:0] key;
  logic [1:0]  trust;

  assign key = {in_word.vendor_id, in_word.product_id};

  always_comb begin
    if (key == cfg.key0) begin
      trust = trust_of_code(cfg.trust_codes[1:0]);
    end else if (key == cfg.key1) begin
      trust = trust_of_code(cfg.trust_codes[3:2]);
    end else if (key == cfg.key2) begin
      trust = trust_of_code(cfg.trust_codes[5:4]);
    end else begin
      trust = TR_UNKNOWN;
    end
  end

  always_comb begin
    q_data           = '0;
    q_data.req       = in_word.req_type;
    q_data.ignored   = (key == cfg.host_key) &&
                       ((in_word.req_type == REQ_ATTACH) || (in_word.req_type == REQ_DETACH));
    q_data.trust     = trust;
    q_data.vendor    = in_word.vendor_id;
    q_data.product   = in_word.product_id;
    q_data.cls_code  = in_word.device_class;
    q_data.speed     = in_word.link_speed;
    q_data.now       = in_word.now_time;
    q_data.cutoff    = in_word.now_time - {1'b0, cfg.timeout};
    q_data.read_slot = in_word.read_slot;
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

endmodule

>>> hdl/devreg_cmdq.sv
// Short command queue between the front end and the registry back end.
// Depends on devreg_pkg.
module devreg_cmdq import devreg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CW = $clog2(CQ_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(CQ_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CQ_DEPTH);

  cmd_t            slot_r [CQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/devreg_back.sv
// Back end: slot table, one-slot-per-cycle scan sequencer and result register.
// Depends on devreg_pkg.
module devreg_back import devreg_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_data,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_word_t out_word
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t          state_r;
  cmd_t            cmd_r;
  logic [IW-1:0]   idx_r;
  logic [IW-1:0]   chk_idx_r;
  logic            chk_vld_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic [DEPTH-1:0] valid_r;
  out_word_t       res_r;
  out_word_t       res_nxt;
  logic            res_full_r;

  entry_t          entry_mem [DEPTH];
  entry_t          rd_data_r;
  entry_t          mem_wdata;
  logic            mem_we;

  logic            take;
  logic            finish;
  logic            set_en;
  logic            clr_en;
  logic            id_match;
  logic            stale;
  logic            in_range;
  logic [31:0]     age_diff;
  logic [IW+3:0]   rs_wide;
  logic [IW-1:0]   rs_idx;
  logic [IW+3:0]   idx_wide;
  logic [IW+3:0]   chk_wide;
  logic [CW+4:0]   cnt_wide;

  assign take     = (state_r == S_IDLE) && !q_empty && !res_full_r;
  assign q_pop    = take;
  assign rs_wide  = {{IW{1'b0}}, q_data.read_slot};
  assign rs_idx   = rs_wide[IW-1:0];
  assign idx_wide = {4'd0, idx_r};
  assign chk_wide = {4'd0, chk_idx_r};
  assign age_diff = rd_data_r.stamp - cmd_r.cutoff;
  assign stale    = age_diff[31];
  assign id_match = (rd_data_r.vendor == cmd_r.vendor) && (rd_data_r.product == cmd_r.product);
  assign in_range = (32'(cmd_r.read_slot) < 32'(DEPTH));

  assign mem_we = (state_r == S_RUN) && (cmd_r.req == REQ_ATTACH) && !valid_r[idx_r];
  always_comb begin
    mem_wdata          = '0;
    mem_wdata.vendor   = cmd_r.vendor;
    mem_wdata.product  = cmd_r.product;
    mem_wdata.cls_code = cmd_r.cls_code;
    mem_wdata.speed    = cmd_r.speed;
    mem_wdata.trust    = cmd_r.trust;
    mem_wdata.stamp    = cmd_r.now;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[idx_r] <= mem_wdata;
    end
    rd_data_r <= entry_mem[idx_r];
  end

  always_comb begin
    res_nxt = '0;
    finish  = 1'b0;
    set_en  = 1'b0;
    clr_en  = 1'b0;
    cnt_nxt = cnt_r;
    if (chk_vld_r && valid_r[chk_idx_r] && stale) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    cnt_wide = {5'd0, cnt_nxt};
    case (state_r)
      S_IDLE: begin
        if (take && q_data.ignored) begin
          res_nxt.status = ST_IGNORED;
          finish         = 1'b1;
        end
      end
      S_RUN: begin
        case (cmd_r.req)
          REQ_ATTACH: begin
            res_nxt.trust_level       = cmd_r.trust;
            res_nxt.blink_count       = blink_count_of(cmd_r.trust);
            res_nxt.blink_half_period = blink_half_of(cmd_r.trust);
            if (!valid_r[idx_r]) begin
              res_nxt.status    = ST_ADDED;
              res_nxt.slot_used = idx_wide[3:0];
              set_en            = 1'b1;
              finish            = 1'b1;
            end else if (idx_r == LAST) begin
              res_nxt.status = ST_FULL;
              finish         = 1'b1;
            end
          end
          REQ_DETACH: begin
            if (chk_vld_r && valid_r[chk_idx_r] && id_match) begin
              res_nxt.status    = ST_REMOVED;
              res_nxt.slot_used = chk_wide[3:0];
              clr_en            = 1'b1;
              finish            = 1'b1;
            end else if (chk_vld_r && (chk_idx_r == LAST)) begin
              res_nxt.status = ST_NOTFOUND;
              finish         = 1'b1;
            end
          end
          REQ_SWEEP: begin
            clr_en = chk_vld_r && valid_r[chk_idx_r] && stale;
            if (chk_vld_r && (chk_idx_r == LAST)) begin
              res_nxt.status      = ST_SWEPT;
              res_nxt.swept_count = cnt_wide[4:0];
              finish              = 1'b1;
            end
          end
          REQ_READ: begin
            if (chk_vld_r) begin
              res_nxt.status    = ST_READ;
              res_nxt.slot_used = cmd_r.read_slot;
              if (in_range) begin
                res_nxt.trust_level      = rd_data_r.trust;
                res_nxt.slot_active      = valid_r[idx_r];
                res_nxt.out_vendor_id    = rd_data_r.vendor;
                res_nxt.out_product_id   = rd_data_r.product;
                res_nxt.out_device_class = rd_data_r.cls_code;
                res_nxt.out_link_speed   = rd_data_r.speed;
              end
              finish = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      res_full_r <= 1'b0;
      chk_vld_r  <= 1'b0;
    end else begin
      if (out_pop && res_full_r) begin
        res_full_r <= 1'b0;
      end
      if (finish) begin
        res_r      <= res_nxt;
        res_full_r <= 1'b1;
      end
      if (set_en) begin
        valid_r[idx_r] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[chk_idx_r] <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (take) begin
            cmd_r     <= q_data;
            chk_vld_r <= 1'b0;
            cnt_r     <= '0;
            idx_r     <= (q_data.req == REQ_READ) ? rs_idx : '0;
            if (!q_data.ignored) begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          cnt_r     <= cnt_nxt;
          chk_idx_r <= idx_r;
          chk_vld_r <= 1'b1;
          if ((cmd_r.req != REQ_READ) && (idx_r != LAST) && !finish) begin
            idx_r <= idx_r + 1'b1;
          end
          if (finish) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_empty = !res_full_r;
  assign out_word  = res_r;

endmodule

>>> hdl/device_registry_with_classify_unit.sv
// Top level of the device registry: configuration registers, front end,
// command queue and back end. Depends on devreg_pkg and the devreg_* modules.
//
//   channel  handshake          word
//   in       in_push / in_full  in_word (in_word_t)
//   out      out_pop / out_empty out_word (out_word_t)
//   cfg      cfg_wr_en          cfg_index, cfg_wdata
//
// In the back end, attach, detach and sweep scan the slot table, read
// looks up one slot, and an ignored host-board word skips the scan; the
// slot scan visits one slot per cycle through the single table read port.
// Two commands queue while the back end scans; a waiting result holds the
// back end until popped. Reset is synchronous, active low, and clears all
// active marks at once.
module device_registry_with_classify_unit import devreg_pkg::*; #(
  parameter int REGISTRY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_word_t    in_word,
  output logic        out_empty,
  input  logic        out_pop,
  output out_word_t   out_word,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cls_cfg_t cfg_r;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  cmd_t     q_wdata;
  cmd_t     q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key0        <= KEY0_RST;
      cfg_r.key1        <= KEY1_RST;
      cfg_r.key2        <= KEY2_RST;
      cfg_r.trust_codes <= TRUST_RST;
      cfg_r.host_key    <= HOST_RST;
      cfg_r.timeout     <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY0:    cfg_r.key0        <= cfg_wdata;
        CFG_KEY1:    cfg_r.key1        <= cfg_wdata;
        CFG_KEY2:    cfg_r.key2        <= cfg_wdata;
        CFG_TRUST:   cfg_r.trust_codes <= cfg_wdata[5:0];
        CFG_HOST:    cfg_r.host_key    <= cfg_wdata;
        CFG_TIMEOUT: cfg_r.timeout     <= cfg_wdata[30:0];
        default:     cfg_r             <= cfg_r;
      endcase
    end
  end

  devreg_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  devreg_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  devreg_back #(
    .DEPTH (REGISTRY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_word)
  );

endmodule

>>> hdl/devreg_checker.sv
// Port-level checker for the device registry, bound to the top level.
// Depends on devreg_pkg and device_registry_with_classify_unit_assert.svh.
`include "device_registry_with_classify_unit_assert.svh"

module devreg_checker import devreg_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input out_word_t out_word
);

  logic attach_res;
  logic blink_ok;
  logic ignored_res;
  logic ignored_zero;
  logic other_res;

  assign attach_res   = !out_empty &&
                        ((out_word.status == ST_ADDED) || (out_word.status == ST_FULL));
  assign blink_ok     = (out_word.blink_count == BLINK_CNT_KNOWN) ||
                        (out_word.blink_count == BLINK_CNT_UNKNOWN) ||
                        (out_word.blink_count == BLINK_CNT_SUSPICIOUS);
  assign ignored_res  = !out_empty && (out_word.status == ST_IGNORED);
  assign ignored_zero = (out_word.trust_level == '0) && (out_word.slot_used == '0) &&
                        (out_word.blink_count == '0) && (out_word.swept_count == '0);
  assign other_res    = !out_empty && (out_word.status != ST_READ);

  `DRC_ASSERT_NEXT(a_out_hold, (!out_empty && !out_pop), (!out_empty && $stable(out_word)))
  `DRC_ASSERT_NOW(a_attach_blink, attach_res, blink_ok)
  `DRC_ASSERT_NOW(a_ignored_zero, ignored_res, ignored_zero)
  `DRC_ASSERT_NOW(a_active_read_only, other_res, (!out_word.slot_active))

endmodule

bind device_registry_with_classify_unit devreg_checker u_devreg_checker (.*);
